>>> rtl/uttr_pkg.sv
// Package for the serial-port ring buffer engine: command and register codes,
// fixed field widths and the per-transaction result record. No dependencies.
package uttr_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 9;
  localparam int unsigned ThrW    = 9;
  localparam int unsigned CmdW    = 2;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgW    = 9;
  localparam int unsigned OutW    = 56;

  localparam logic [ThrW-1:0] BurstThrReset = 9'd16;

  typedef enum logic [CmdW-1:0] {
    CMD_PUSH    = 2'd0,
    CMD_POP     = 2'd1,
    CMD_RX_BYTE = 2'd2,
    CMD_TX_DONE = 2'd3
  } uttr_cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BURST_EN  = 1'b0,
    CFG_BURST_THR = 1'b1
  } uttr_cfg_e;

  // Result fields known right after the pointer update; ring bytes come from
  // the registered read ports of the memories in the next cycle.
  typedef struct packed {
    logic             push_accepted;
    logic             rx_valid;
    logic             rx_overrun;
    logic             tx_issue;
    logic [ByteW-1:0] tx_start;
    logic [LenW-1:0]  tx_length;
    logic             tx_busy;
    logic [ByteW-1:0] rx_fill;
    logic [ByteW-1:0] tx_pending;
  } uttr_meta_t;

endpackage

>>> rtl/uttr_ring_ram.sv
// Byte ring storage: one write port, one read port with registered data.
// A read of the slot written in the same cycle returns the new byte. Uses uttr_pkg.
module uttr_ring_ram
  import uttr_pkg::*;
#(
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [ByteW-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [ByteW-1:0]         rdata_o
);

  logic [ByteW-1:0] mem [DEPTH];
  logic [ByteW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      // forward a same-cycle write to the read port
      rdata_q <= (we_i && (waddr_i == raddr_i)) ? wdata_i : mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/uttr_ctrl.sv
// Ring pointer control: decodes a command, updates head/tail pointers and the
// transmit state, and issues ring memory accesses. Uses uttr_pkg.
module uttr_ctrl
  import uttr_pkg::*;
#(
  parameter int unsigned TX_DEPTH = 256,
  parameter int unsigned RX_DEPTH = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [CfgIdxW-1:0]          cfg_addr_i,
  input  logic [CfgW-1:0]             cfg_wdata_i,
  input  logic                        fire_i,
  input  logic [CmdW-1:0]             cmd_i,
  output uttr_meta_t                  meta_o,
  output logic                        tx_we_o,
  output logic [$clog2(TX_DEPTH)-1:0] tx_waddr_o,
  output logic                        tx_re_o,
  output logic [$clog2(TX_DEPTH)-1:0] tx_raddr_o,
  output logic                        rx_we_o,
  output logic [$clog2(RX_DEPTH)-1:0] rx_waddr_o,
  output logic                        rx_re_o,
  output logic [$clog2(RX_DEPTH)-1:0] rx_raddr_o
);

  localparam int unsigned TXW  = $clog2(TX_DEPTH);
  localparam int unsigned RXW  = $clog2(RX_DEPTH);
  localparam int unsigned CMPW = (TXW > ThrW) ? TXW : ThrW;
  localparam logic [TXW-1:0] TxLast = TXW'(TX_DEPTH - 1);
  localparam logic [RXW-1:0] RxLast = RXW'(RX_DEPTH - 1);
  localparam logic [TXW:0]   TxSize = (TXW + 1)'(TX_DEPTH);
  localparam logic [RXW:0]   RxSize = (RXW + 1)'(RX_DEPTH);

  function automatic logic [TXW-1:0] tx_inc(input logic [TXW-1:0] p);
    return (p == TxLast) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [RXW-1:0] rx_inc(input logic [RXW-1:0] p);
    return (p == RxLast) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [TXW-1:0] tx_cnt(input logic [TXW-1:0] h, input logic [TXW-1:0] t);
    logic [TXW:0] s;
    s = (h >= t) ? ({1'b0, h} - {1'b0, t}) : ({1'b0, h} + TxSize - {1'b0, t});
    return s[TXW-1:0];
  endfunction

  function automatic logic [RXW-1:0] rx_cnt(input logic [RXW-1:0] h, input logic [RXW-1:0] t);
    logic [RXW:0] s;
    s = (h >= t) ? ({1'b0, h} - {1'b0, t}) : ({1'b0, h} + RxSize - {1'b0, t});
    return s[RXW-1:0];
  endfunction

  logic [TXW-1:0]  tx_head_q, tx_head_d, tx_tail_q, tx_tail_d;
  logic [TXW-1:0]  tx_next_tail_q, tx_next_tail_d;
  logic            tx_active_q, tx_active_d;
  logic [RXW-1:0]  rx_head_q, rx_head_d, rx_tail_q, rx_tail_d;
  logic            burst_en_q;
  logic [ThrW-1:0] burst_thr_q;

  uttr_cmd_e       cmd;
  logic            push_ok, do_launch, issue, burst;
  logic [TXW-1:0]  l_tail, l_pend, l_next;
  logic [TXW:0]    l_len;

  assign cmd = uttr_cmd_e'(cmd_i);

  always_comb begin
    tx_head_d      = tx_head_q;
    tx_tail_d      = tx_tail_q;
    tx_active_d    = tx_active_q;
    rx_head_d      = rx_head_q;
    rx_tail_d      = rx_tail_q;
    push_ok        = 1'b0;
    do_launch      = 1'b0;
    l_tail         = tx_tail_q;
    meta_o         = '0;
    tx_we_o        = 1'b0;
    rx_we_o        = 1'b0;
    rx_re_o        = 1'b0;

    unique case (cmd)
      CMD_PUSH: begin
        push_ok   = (tx_cnt(tx_head_q, tx_tail_q) != TxLast);
        tx_we_o   = fire_i && push_ok;
        if (push_ok) begin
          tx_head_d = tx_inc(tx_head_q);
        end
        do_launch = !tx_active_q;
      end
      CMD_POP: begin
        if (rx_head_q != rx_tail_q) begin
          meta_o.rx_valid = 1'b1;
          rx_re_o         = fire_i;
          rx_tail_d       = rx_inc(rx_tail_q);
        end
      end
      CMD_RX_BYTE: begin
        rx_we_o   = fire_i;
        rx_head_d = rx_inc(rx_head_q);
        // full ring: drop the oldest byte
        if (rx_inc(rx_head_q) == rx_tail_q) begin
          rx_tail_d         = rx_inc(rx_tail_q);
          meta_o.rx_overrun = 1'b1;
        end
      end
      CMD_TX_DONE: begin
        if (tx_active_q) begin
          tx_tail_d = tx_next_tail_q;
          l_tail    = tx_next_tail_q;
          if (tx_next_tail_q == tx_head_q) begin
            tx_active_d = 1'b0;
          end else begin
            do_launch = 1'b1;
          end
        end
      end
      default: ;
    endcase

    // transfer start from l_tail: one byte, or in burst mode up to the updated head or the wrap point
    l_pend = tx_cnt(tx_head_d, l_tail);
    issue  = do_launch && (l_pend != '0);
    burst  = burst_en_q && (CMPW'(l_pend) >= CMPW'(burst_thr_q));
    if (!burst) begin
      l_len  = (TXW + 1)'(1);
      l_next = tx_inc(l_tail);
    end else if (tx_head_d < l_tail) begin
      l_len  = TxSize - {1'b0, l_tail};
      l_next = '0;
    end else begin
      l_len  = {1'b0, tx_head_d} - {1'b0, l_tail};
      l_next = tx_head_d;
    end
    tx_next_tail_d = issue ? l_next : tx_next_tail_q;
    if (issue) begin
      tx_active_d      = 1'b1;
      meta_o.tx_issue  = 1'b1;
      meta_o.tx_start  = ByteW'(l_tail);
      meta_o.tx_length = LenW'(l_len);
    end

    meta_o.push_accepted = push_ok;
    meta_o.tx_busy       = tx_active_d;
    meta_o.rx_fill       = ByteW'(rx_cnt(rx_head_d, rx_tail_d));
    meta_o.tx_pending    = ByteW'(tx_cnt(tx_head_d, tx_tail_d));
  end

  assign tx_waddr_o = tx_head_q;
  assign tx_re_o    = fire_i && issue;
  assign tx_raddr_o = l_tail;
  assign rx_waddr_o = rx_head_q;
  assign rx_raddr_o = rx_tail_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_head_q      <= '0;
      tx_tail_q      <= '0;
      tx_next_tail_q <= '0;
      tx_active_q    <= 1'b0;
      rx_head_q      <= '0;
      rx_tail_q      <= '0;
    end else if (fire_i) begin
      tx_head_q      <= tx_head_d;
      tx_tail_q      <= tx_tail_d;
      tx_next_tail_q <= tx_next_tail_d;
      tx_active_q    <= tx_active_d;
      rx_head_q      <= rx_head_d;
      rx_tail_q      <= rx_tail_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      burst_en_q  <= 1'b0;
      burst_thr_q <= BurstThrReset;
    end else if (cfg_we_i) begin
      unique case (uttr_cfg_e'(cfg_addr_i))
        CFG_BURST_EN:  burst_en_q  <= cfg_wdata_i[0];
        CFG_BURST_THR: burst_thr_q <= cfg_wdata_i[ThrW-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/uart_tx_rx_ring_buffer_engine.sv
// Serial-port ring buffer engine: transmit and receive byte rings, pointer
// control and output staging. Depends on uttr_pkg, uttr_ctrl and uttr_ring_ram.

// Each input transaction carries one command (push, pop, line byte received,
// transmit complete) and yields exactly one result transaction. The block takes
// one command per cycle unless the output is stalled: pointers are updated in
// the cycle the command is taken and the ring slot read for a pop or a transfer
// start comes out of the registered ring memory port in the next cycle, while
// the fetch stage holds the other result fields. A fetch stage and an output
// register let a new command enter while an earlier result waits to be taken.
// Ring slot contents are not initialized at reset; only slots that were written are ever returned.
module uart_tx_rx_ring_buffer_engine
  import uttr_pkg::*;
#(
  parameter int unsigned TX_DEPTH = 256,
  parameter int unsigned RX_DEPTH = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_addr_i,
  input  logic [CfgW-1:0]     cfg_wdata_i,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // data_byte
  input  logic [ByteW-1:0]    s_axis_tdata_i,
  // command
  input  logic [CmdW-1:0]     s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // push_accepted, rx_valid, rx_byte, rx_overrun, tx_issue, tx_start,
  // tx_length, tx_first_byte, tx_busy, rx_fill, tx_pending, zero pad
  output logic [OutW-1:0]     m_axis_tdata_o
);

  localparam int unsigned TXW = $clog2(TX_DEPTH);
  localparam int unsigned RXW = $clog2(RX_DEPTH);

  logic           fire, s1_move;
  uttr_meta_t     meta;
  logic           tx_we, tx_re, rx_we, rx_re;
  logic [TXW-1:0] tx_waddr, tx_raddr;
  logic [RXW-1:0] rx_waddr, rx_raddr;
  logic [ByteW-1:0] tx_rdata, rx_rdata;

  logic           s1_valid_q;
  uttr_meta_t     s1_meta_q;
  logic           out_valid_q;
  logic [OutW-1:0] out_q, out_d;

  assign s1_move         = s1_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_valid_q || s1_move;
  assign fire            = s_axis_tvalid_i && s_axis_tready_o;

  uttr_ctrl #(
    .TX_DEPTH (TX_DEPTH),
    .RX_DEPTH (RX_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (fire),
    .cmd_i       (s_axis_tuser_i),
    .meta_o      (meta),
    .tx_we_o     (tx_we),
    .tx_waddr_o  (tx_waddr),
    .tx_re_o     (tx_re),
    .tx_raddr_o  (tx_raddr),
    .rx_we_o     (rx_we),
    .rx_waddr_o  (rx_waddr),
    .rx_re_o     (rx_re),
    .rx_raddr_o  (rx_raddr)
  );

  uttr_ring_ram #(
    .DEPTH (TX_DEPTH)
  ) u_tx_ram (
    .clk_i   (clk_i),
    .we_i    (tx_we),
    .waddr_i (tx_waddr),
    .wdata_i (s_axis_tdata_i),
    .re_i    (tx_re),
    .raddr_i (tx_raddr),
    .rdata_o (tx_rdata)
  );

  uttr_ring_ram #(
    .DEPTH (RX_DEPTH)
  ) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (rx_we),
    .waddr_i (rx_waddr),
    .wdata_i (s_axis_tdata_i),
    .re_i    (rx_re),
    .raddr_i (rx_raddr),
    .rdata_o (rx_rdata)
  );

  // merge ring bytes into the result; zero them when not returned
  always_comb begin
    out_d = {
      2'b00,
      s1_meta_q.tx_pending,
      s1_meta_q.rx_fill,
      s1_meta_q.tx_busy,
      (s1_meta_q.tx_issue ? tx_rdata : {ByteW{1'b0}}),
      s1_meta_q.tx_length,
      s1_meta_q.tx_start,
      s1_meta_q.tx_issue,
      s1_meta_q.rx_overrun,
      (s1_meta_q.rx_valid ? rx_rdata : {ByteW{1'b0}}),
      s1_meta_q.rx_valid,
      s1_meta_q.push_accepted
    };
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      s1_meta_q <= meta;
    end
    if (s1_move) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

endmodule

>>> tb/tb.sv
// Testbench for the serial-port ring buffer engine: streams commands in, predicts
// each result transaction from its own copy of both rings and checks every field.
// Depends on uttr_pkg and uart_tx_rx_ring_buffer_engine.
module tb;
  import uttr_pkg::*;

  localparam int unsigned RingDepth   = 256;
  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned RandomItems = 40;
  localparam int unsigned ReportMax   = 10;

  // Result transaction layout, lowest field last.
  typedef struct packed {
    logic [1:0]       pad;
    logic [ByteW-1:0] tx_pending;
    logic [ByteW-1:0] rx_fill;
    logic             tx_busy;
    logic [ByteW-1:0] tx_first_byte;
    logic [LenW-1:0]  tx_length;
    logic [ByteW-1:0] tx_start;
    logic             tx_issue;
    logic             rx_overrun;
    logic [ByteW-1:0] rx_byte;
    logic             rx_valid;
    logic             push_accepted;
  } ring_result_t;

  typedef enum logic [1:0] {
    DRAIN_FULL,
    DRAIN_SOME,
    DRAIN_RARE
  } drain_mode_e;

  logic             clk_i     = 1'b0;
  logic             rst_ni    = 1'b0;
  logic             cfg_we    = 1'b0;
  uttr_cfg_e        cfg_addr  = CFG_BURST_EN;
  logic [CfgW-1:0]  cfg_wdata = '0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  logic [ByteW-1:0] in_byte   = '0;
  uttr_cmd_e        in_cmd    = CMD_PUSH;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [OutW-1:0]  out_data;

  uart_tx_rx_ring_buffer_engine dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_addr_i     (cfg_addr),
    .cfg_wdata_i    (cfg_wdata),
    .s_axis_tvalid_i(in_valid),
    .s_axis_tready_o(in_ready),
    .s_axis_tdata_i (in_byte),
    .s_axis_tuser_i (in_cmd),
    .m_axis_tvalid_o(out_valid),
    .m_axis_tready_i(out_ready),
    .m_axis_tdata_o (out_data)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow copy of both rings and the transmit state.
  logic [ByteW-1:0] tx_ring [RingDepth];
  logic [ByteW-1:0] rx_ring [RingDepth];
  logic [ByteW-1:0] tx_wr_ptr  = '0;
  logic [ByteW-1:0] tx_rd_ptr  = '0;
  logic [ByteW-1:0] tx_rd_next = '0;
  logic             tx_running = 1'b0;
  logic [ByteW-1:0] rx_wr_ptr  = '0;
  logic [ByteW-1:0] rx_rd_ptr  = '0;
  logic             burst_on   = 1'b0;
  logic [ThrW-1:0]  burst_min  = BurstThrReset;

  ring_result_t expected_results[$];
  int unsigned  errors = 0;

  // Start a transfer from the read pointer when bytes wait.
  function automatic void start_transfer(inout ring_result_t r);
    logic [ByteW-1:0] waiting;
    logic [LenW-1:0]  len;
    waiting = tx_wr_ptr - tx_rd_ptr;
    if (waiting == '0) return;
    if (!burst_on || {1'b0, waiting} < burst_min) begin
      len        = 9'd1;
      tx_rd_next = tx_rd_ptr + 8'd1;
    end else if (tx_wr_ptr < tx_rd_ptr) begin
      // run to the wrap point
      len        = LenW'(RingDepth) - {1'b0, tx_rd_ptr};
      tx_rd_next = '0;
    end else begin
      len        = {1'b0, waiting};
      tx_rd_next = tx_wr_ptr;
    end
    tx_running      = 1'b1;
    r.tx_issue      = 1'b1;
    r.tx_start      = tx_rd_ptr;
    r.tx_length     = len;
    r.tx_first_byte = tx_ring[tx_rd_ptr];
  endfunction

  function automatic ring_result_t apply_command(uttr_cmd_e cmd, logic [ByteW-1:0] b);
    ring_result_t     r;
    logic [ByteW-1:0] used;
    r = '0;
    case (cmd)
      CMD_PUSH: begin
        used = tx_wr_ptr - tx_rd_ptr;
        // one slot always stays free
        if (used != 8'hFF) begin
          tx_ring[tx_wr_ptr] = b;
          tx_wr_ptr          = tx_wr_ptr + 8'd1;
          r.push_accepted    = 1'b1;
        end
        if (!tx_running) start_transfer(r);
      end
      CMD_POP: begin
        if (rx_wr_ptr != rx_rd_ptr) begin
          r.rx_valid = 1'b1;
          r.rx_byte  = rx_ring[rx_rd_ptr];
          rx_rd_ptr  = rx_rd_ptr + 8'd1;
        end
      end
      CMD_RX_BYTE: begin
        rx_ring[rx_wr_ptr] = b;
        rx_wr_ptr          = rx_wr_ptr + 8'd1;
        // drop the oldest byte on overflow
        if (rx_wr_ptr == rx_rd_ptr) begin
          rx_rd_ptr    = rx_rd_ptr + 8'd1;
          r.rx_overrun = 1'b1;
        end
      end
      CMD_TX_DONE: begin
        if (tx_running) begin
          tx_rd_ptr = tx_rd_next;
          if (tx_rd_ptr == tx_wr_ptr) tx_running = 1'b0;
          else start_transfer(r);
        end
      end
      default: ;
    endcase
    r.tx_busy    = tx_running;
    r.rx_fill    = rx_wr_ptr - rx_rd_ptr;
    r.tx_pending = tx_wr_ptr - tx_rd_ptr;
    return r;
  endfunction

  function automatic string describe(ring_result_t r);
    return $sformatf({"acc=%0d rxv=%0d rxb=%02h ovr=%0d iss=%0d start=%0d len=%0d ",
                      "first=%02h busy=%0d rxfill=%0d txpend=%0d pad=%0d"},
                     r.push_accepted, r.rx_valid, r.rx_byte, r.rx_overrun, r.tx_issue,
                     r.tx_start, r.tx_length, r.tx_first_byte, r.tx_busy, r.rx_fill,
                     r.tx_pending, r.pad);
  endfunction

  // Sender: bursts of random length separated by random gaps.
  int unsigned burst_left = 0;

  task automatic send_command(uttr_cmd_e cmd, logic [ByteW-1:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 8);
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        @(negedge clk_i);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_cmd   <= cmd;
    in_byte  <= b;
    do @(posedge clk_i); while (!in_ready);
    expected_results.push_back(apply_command(cmd, b));
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid <= 1'b0;
    burst_left = 0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(uttr_cfg_e idx, logic [CfgW-1:0] val);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    if (idx == CFG_BURST_EN) burst_on = val[0];
    else burst_min = val[ThrW-1:0];
  endtask

  // Receiver: stretches of full rate, light stalls and heavy stalls.
  drain_mode_e drain_mode = DRAIN_FULL;
  int unsigned mode_left  = 0;

  always @(negedge clk_i) begin
    if (mode_left == 0) begin
      drain_mode = drain_mode_e'($urandom_range(0, 2));
      mode_left  = $urandom_range(10, 120);
    end
    mode_left--;
    case (drain_mode)
      DRAIN_FULL: out_ready <= 1'b1;
      DRAIN_SOME: out_ready <= ($urandom_range(0, 3) != 0);
      default:    out_ready <= ($urandom_range(0, 4) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    ring_result_t got;
    ring_result_t want;
    if (rst_ni && out_valid && out_ready) begin
      got = out_data;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= ReportMax) $display("unexpected result: %s", describe(got));
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= ReportMax) begin
            $display("result mismatch");
            $display("  expected %s", describe(want));
            $display("  actual   %s", describe(got));
          end
        end
      end
    end
  end

  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == StallLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic check_empty_ring_commands();
    send_command(CMD_POP, 8'h00);
    send_command(CMD_TX_DONE, 8'hFF);
  endtask

  // Reset config: bursts off, so every transfer is one byte.
  task automatic check_single_byte_transfers();
    send_command(CMD_PUSH, 8'h00);
    send_command(CMD_PUSH, 8'hFF);
    send_command(CMD_TX_DONE, 8'h00);
    send_command(CMD_TX_DONE, 8'h00);
    send_command(CMD_TX_DONE, 8'h00);
  endtask

  task automatic check_receive_path();
    send_command(CMD_RX_BYTE, 8'h00);
    send_command(CMD_RX_BYTE, 8'hFF);
    send_command(CMD_RX_BYTE, 8'h5A);
    repeat (4) send_command(CMD_POP, 8'h00);
  endtask

  task automatic check_zero_threshold_bursts();
    wait_idle();
    write_reg(CFG_BURST_EN, 9'd1);
    write_reg(CFG_BURST_THR, 9'd0);
    send_command(CMD_PUSH, 8'hA5);
    send_command(CMD_PUSH, 8'h3C);
    send_command(CMD_PUSH, 8'hC3);
    send_command(CMD_TX_DONE, 8'h00);
    send_command(CMD_TX_DONE, 8'h00);
  endtask

  // Fill both rings past capacity, then burst up to the head and across the wrap.
  task automatic check_full_rings_and_wrap();
    wait_idle();
    write_reg(CFG_BURST_THR, 9'd256);
    repeat (RingDepth + 2) send_command(CMD_PUSH, 8'($urandom_range(0, 255)));
    repeat (RingDepth + 2) send_command(CMD_RX_BYTE, 8'($urandom_range(0, 255)));
    wait_idle();
    write_reg(CFG_BURST_THR, 9'd1);
    send_command(CMD_TX_DONE, 8'h00);
    send_command(CMD_TX_DONE, 8'h00);
    repeat (5) send_command(CMD_PUSH, 8'($urandom_range(0, 255)));
    repeat (3) send_command(CMD_TX_DONE, 8'h00);
    repeat (20) send_command(CMD_POP, 8'h00);
  endtask

  task automatic check_random_traffic();
    int unsigned sent;
    int unsigned n;
    int unsigned w_push, w_pop, w_rx, w_done, pick;
    logic [CfgW-1:0] thr;
    sent = 0;
    while (sent < RandomItems) begin
      wait_idle();
      case ($urandom_range(0, 4))
        0:       thr = 9'd1;
        1:       thr = 9'd256;
        2:       thr = 9'($urandom_range(2, 8));
        3:       thr = 9'($urandom_range(9, 64));
        default: thr = 9'($urandom_range(65, 255));
      endcase
      write_reg(CFG_BURST_EN, 9'($urandom_range(0, 1)));
      write_reg(CFG_BURST_THR, thr);
      w_push = $urandom_range(1, 8);
      w_pop  = $urandom_range(1, 8);
      w_rx   = $urandom_range(1, 8);
      w_done = $urandom_range(1, 8);
      n      = $urandom_range(40, 120);
      repeat (n) begin
        pick = $urandom_range(0, w_push + w_pop + w_rx + w_done - 1);
        if (pick < w_push)
          send_command(CMD_PUSH, 8'($urandom_range(0, 255)));
        else if (pick < w_push + w_pop)
          send_command(CMD_POP, 8'($urandom_range(0, 255)));
        else if (pick < w_push + w_pop + w_rx)
          send_command(CMD_RX_BYTE, 8'($urandom_range(0, 255)));
        else
          send_command(CMD_TX_DONE, 8'($urandom_range(0, 255)));
      end
      sent += n;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    check_empty_ring_commands();
    check_single_byte_transfers();
    check_receive_path();
    check_zero_threshold_bursts();
    check_full_rings_and_wrap();
    check_random_traffic();
    wait_idle();
    repeat (8) @(posedge clk_i);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
